### rtl/sfcd_pkg.sv
`default_nettype none
package sfcd_pkg;

   localparam int MOTOR_COUNT = 5;
   localparam int BYTE_W      = 8;
   localparam int MOTOR_IDX_W = 3;
   localparam int IDX_W       = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;
   localparam int POS_W       = $clog2(MOTOR_COUNT + 2);
   localparam int POS_CHECK   = MOTOR_COUNT + 1;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [BYTE_W-1:0] SYNC_RESET = 8'h7A;

   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_ERR = 1'b1;

   typedef logic [BYTE_W-1:0] byte_type;

   typedef struct packed {
      logic                              err;
      logic [MOTOR_COUNT-1:0][BYTE_W-1:0] payload;
   } frame_cmd_type;

   typedef struct packed {
      logic push;
   } queue_ctl_type;

endpackage
`default_nettype wire

### rtl/sfcd_req_if.sv
`default_nettype none
interface sfcd_req_if;
   logic                     valid;
   logic                     ready;
   logic [sfcd_pkg::BYTE_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface
`default_nettype wire

### rtl/sfcd_rsp_if.sv
`default_nettype none
interface sfcd_rsp_if;
   logic                             valid;
   logic                             ready;
   logic                             status;
   logic [sfcd_pkg::MOTOR_IDX_W-1:0] motor_index;
   logic                             power_on;
   logic [1:0]                       speed_code;
   logic [4:0]                       angle_code;
   logic                             last;

   modport source (output valid, output status, output motor_index, output power_on,
                   output speed_code, output angle_code, output last, input ready);
   modport sink (input valid, input status, input motor_index, input power_on,
                 input speed_code, input angle_code, input last, output ready);
endinterface
`default_nettype wire

### rtl/sfcd_front.sv
`default_nettype none
module sfcd_front (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic [sfcd_pkg::BYTE_W-1:0] sync_value,
   input  wire logic                      in_valid,
   output logic                           in_ready,
   input  wire logic [sfcd_pkg::BYTE_W-1:0] in_byte,
   input  wire logic                      q_full,
   output sfcd_pkg::queue_ctl_type        q_ctl,
   output sfcd_pkg::frame_cmd_type        q_data
);

   logic [sfcd_pkg::POS_W-1:0]  pos_ff, pos_in;
   logic [sfcd_pkg::BYTE_W-1:0] sum_ff, sum_in;
   logic [sfcd_pkg::MOTOR_COUNT-1:0][sfcd_pkg::BYTE_W-1:0] store_ff;
   logic [sfcd_pkg::IDX_W-1:0]  wr_idx;
   logic                        at_check;
   logic                        accept;

   assign at_check = (pos_ff == sfcd_pkg::POS_W'(sfcd_pkg::POS_CHECK));
   assign in_ready = !(at_check && q_full);
   assign accept   = in_valid && in_ready;
   assign wr_idx   = sfcd_pkg::IDX_W'(pos_ff - sfcd_pkg::POS_W'(1));

   assign q_ctl.push     = accept && at_check;
   assign q_data.err     = (sum_ff != in_byte);
   assign q_data.payload = store_ff;

   always_comb begin
      pos_in = pos_ff;
      sum_in = sum_ff;
      if (accept) begin
         if (pos_ff == '0) begin
            sum_in = sync_value;
            if (in_byte == sync_value) begin
               pos_in = sfcd_pkg::POS_W'(1);
            end
         end else if (at_check) begin
            pos_in = '0;
         end else begin
            sum_in = sum_ff + in_byte;
            pos_in = pos_ff + sfcd_pkg::POS_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         sum_ff <= '0;
      end else begin
         pos_ff <= pos_in;
         sum_ff <= sum_in;
      end
   end

   // payload bytes, no reset
   always_ff @(posedge clock) begin
      if (accept && pos_ff != '0 && !at_check) begin
         store_ff[wr_idx] <= in_byte;
      end
   end

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= sfcd_pkg::POS_W'(sfcd_pkg::POS_CHECK))
      else $error("frame position out of range");

endmodule
`default_nettype wire

### rtl/sfcd_queue.sv
`default_nettype none
module sfcd_queue (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire sfcd_pkg::queue_ctl_type wr_ctl,
   input  wire sfcd_pkg::frame_cmd_type wr_data,
   output logic                         full,
   output logic                         rd_valid,
   input  wire logic                    rd_pop,
   output sfcd_pkg::frame_cmd_type      rd_data
);

   localparam int PTR_W = $clog2(sfcd_pkg::QUEUE_DEPTH);
   localparam int CNT_W = $clog2(sfcd_pkg::QUEUE_DEPTH + 1);

   sfcd_pkg::frame_cmd_type entry_ff [sfcd_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(sfcd_pkg::QUEUE_DEPTH));
   assign rd_valid = (count_ff != '0);
   assign rd_data  = entry_ff[rd_ptr_ff];
   assign do_push  = wr_ctl.push && !full;
   assign do_pop   = rd_pop && rd_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(sfcd_pkg::QUEUE_DEPTH - 1)) ? '0
                     : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(sfcd_pkg::QUEUE_DEPTH - 1)) ? '0
                     : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(sfcd_pkg::QUEUE_DEPTH))
      else $error("queue count beyond depth");

endmodule
`default_nettype wire

### rtl/sfcd_back.sv
`default_nettype none
module sfcd_back (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    q_valid,
   output logic                         q_pop,
   input  wire sfcd_pkg::frame_cmd_type q_data,
   sfcd_rsp_if.source                   rsp
);

   logic                             busy_ff, busy_in;
   sfcd_pkg::frame_cmd_type          cmd_ff;
   logic [sfcd_pkg::IDX_W-1:0]       idx_ff, idx_in;
   logic                             valid_ff, valid_in;
   logic                             status_ff, status_in;
   logic [sfcd_pkg::MOTOR_IDX_W-1:0] motor_ff, motor_in;
   logic [sfcd_pkg::BYTE_W-1:0]      byte_ff, byte_in;
   logic                             last_ff, last_in;
   logic                             advance;
   logic                             final_one;

   assign advance   = !valid_ff || rsp.ready;
   assign q_pop     = !busy_ff && q_valid;
   assign final_one = cmd_ff.err || (idx_ff == sfcd_pkg::IDX_W'(sfcd_pkg::MOTOR_COUNT - 1));

   always_comb begin
      busy_in   = busy_ff;
      idx_in    = idx_ff;
      valid_in  = valid_ff;
      status_in = status_ff;
      motor_in  = motor_ff;
      byte_in   = byte_ff;
      last_in   = last_ff;
      if (q_pop) begin
         busy_in = 1'b1;
         idx_in  = '0;
      end
      if (advance) begin
         valid_in = busy_ff;
         if (busy_ff) begin
            last_in = final_one;
            if (cmd_ff.err) begin
               status_in = sfcd_pkg::STATUS_ERR;
               motor_in  = '0;
               byte_in   = '0;
            end else begin
               status_in = sfcd_pkg::STATUS_OK;
               motor_in  = sfcd_pkg::MOTOR_IDX_W'(idx_ff);
               byte_in   = cmd_ff.payload[idx_ff];
            end
            if (final_one) begin
               busy_in = 1'b0;
            end else begin
               idx_in = idx_ff + sfcd_pkg::IDX_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         valid_ff <= valid_in;
      end
      idx_ff    <= idx_in;
      status_ff <= status_in;
      motor_ff  <= motor_in;
      byte_ff   <= byte_in;
      last_ff   <= last_in;
      if (q_pop) begin
         cmd_ff <= q_data;
      end
   end

   assign rsp.valid       = valid_ff;
   assign rsp.status      = status_ff;
   assign rsp.motor_index = motor_ff;
   assign rsp.power_on    = byte_ff[0];
   assign rsp.speed_code  = byte_ff[2:1];
   assign rsp.angle_code  = byte_ff[7:3];
   assign rsp.last        = last_ff;

   a_err_is_last: assert property (@(posedge clock) disable iff (reset)
      valid_ff && status_ff == sfcd_pkg::STATUS_ERR |-> last_ff && motor_ff == '0)
      else $error("error word must be single and last");

   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> idx_ff <= sfcd_pkg::IDX_W'(sfcd_pkg::MOTOR_COUNT - 1))
      else $error("motor index out of range");

endmodule
`default_nettype wire

### rtl/sync_frame_command_decoder.sv
// a frame is queued at its checksum word, then popped into the output stage
// in: one word per cycle unless stalled; good frame out: one word per ready cycle
// a two-entry frame queue lets up to two finished frames wait on the result side
// input stalls only on a checksum word while that queue is full
// reset (synchronous, active high) returns to hunting, empties the queue, sync = 0x7a
`default_nettype none
module sync_frame_command_decoder (
   input  wire logic                        clock,
   input  wire logic                        reset,
   sfcd_req_if.sink                         req_byte,
   sfcd_rsp_if.source                       rsp_cmd,
   input  wire logic                        csr_we,
   input  wire logic [sfcd_pkg::BYTE_W-1:0] csr_wdata
);

   logic [sfcd_pkg::BYTE_W-1:0] sync_ff;
   sfcd_pkg::queue_ctl_type     q_ctl;
   sfcd_pkg::frame_cmd_type     q_wr_data;
   sfcd_pkg::frame_cmd_type     q_rd_data;
   logic                        q_full;
   logic                        q_valid;
   logic                        q_pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_ff <= sfcd_pkg::SYNC_RESET;
      end else if (csr_we) begin
         sync_ff <= csr_wdata;
      end
   end

   sfcd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .sync_value (sync_ff),
      .in_valid   (req_byte.valid),
      .in_ready   (req_byte.ready),
      .in_byte    (req_byte.rx_byte),
      .q_full     (q_full),
      .q_ctl      (q_ctl),
      .q_data     (q_wr_data)
   );

   sfcd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_ctl   (q_ctl),
      .wr_data  (q_wr_data),
      .full     (q_full),
      .rd_valid (q_valid),
      .rd_pop   (q_pop),
      .rd_data  (q_rd_data)
   );

   sfcd_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_pop   (q_pop),
      .q_data  (q_rd_data),
      .rsp     (rsp_cmd)
   );

endmodule
`default_nettype wire
